/* sv/kae_pkg.sv */
// shared types and constants for the key autorepeat engine
package kae_pkg;

  localparam int unsigned KEY_W        = 6;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned HELD_W       = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned NUM_KEYS_DEF = 64;

  localparam logic [CFG_W-1:0]     DEFAULT_DELAY  = 7'd21;
  localparam logic [CFG_W-1:0]     DEFAULT_PERIOD = 7'd3;
  localparam logic [HELD_W-1:0]    HELD_MAX       = 7'd127;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic             is_modifier;
  } kae_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] repeat_key;
    logic             last;
  } kae_out_t;

endpackage

/* sv/key_autorepeat_engine.sv */
// key autorepeat engine: per-key repeat counters scanned on each timer tick while the held count is nonzero
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_i  (kind, key, is_modifier)
//   out     | output    | out_valid_o / out_ready_i | out_o (repeat_key, last)
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// key-up is a single write of the counter memory, key-down a read then a write of it
// a tick with keys held reads and updates every key in turn, then flushes the last repeat;
//   the one-read one-write counter memory walks one key per cycle while the scan is not stalled
// after reset all counters read as idle through per-key valid bits, no clearing pass
// the scan stalls only when a repeat must move to the output register while it is full
module key_autorepeat_engine import kae_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kae_in_t              in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kae_out_t             out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(NUM_KEYS);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(NUM_KEYS - 1);
  localparam logic [KEY_W:0]   NUM_KEYS_L = (KEY_W + 1)'(NUM_KEYS);
  localparam logic signed [CNT_W-1:0] CNT_M1 = CNT_W'(-1);
  localparam logic signed [CNT_W-1:0] CNT_P1 = CNT_W'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DOWN  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CFG_W-1:0]  delay_q, period_q;
  logic [HELD_W-1:0] held_q, held_d;
  logic [IDX_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  kae_out_t          out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [CNT_W-1:0]  cnt_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] ent_vld_q;
  logic [CNT_W-1:0]  rd_data_q;
  logic              rd_vld_q;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [CNT_W-1:0]  wr_data;

  logic signed [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0]  period_ext;
  logic              out_free, in_range, fire, stall;
  logic [IDX_W-1:0]  in_idx;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  assign cur_cnt    = rd_vld_q ? rd_data_q : '0;
  assign period_ext = {1'b0, period_q};
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_range   = ({1'b0, in_i.key} < NUM_KEYS_L);
  assign in_idx     = in_i.key[IDX_W-1:0];
  assign fire       = (cur_cnt == CNT_M1) || (cur_cnt == CNT_P1);
  assign stall      = fire && pend_vld_q && !out_free;

  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    key_d      = key_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_i.kind)
            KIND_DOWN: begin
              if (!in_i.is_modifier && in_range) begin
                rd_en   = 1'b1;
                rd_addr = in_idx;
                key_d   = in_idx;
                state_d = ST_DOWN;
              end
            end
            KIND_UP: begin
              if (in_range) begin
                wr_en   = 1'b1;
                wr_addr = in_idx;
                wr_data = '0;
                held_d  = (held_q == '0) ? '0 : held_q - 1'b1;
              end
            end
            KIND_TICK: begin
              if (held_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                cur_d   = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = key_q;
        if (cur_cnt == '0) begin
          held_d  = (held_q == HELD_MAX) ? held_q : held_q + 1'b1;
          wr_data = CNT_W'(0) - {1'b0, delay_q};
        end else begin
          wr_data = period_ext;
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (!stall) begin
          wr_en   = 1'b1;
          wr_addr = cur_q;
          if (fire) begin
            wr_data = period_ext;
            if (pend_vld_q) begin
              out_d.repeat_key = KEY_W'(pend_q);
              out_d.last       = 1'b0;
              out_vld_d        = 1'b1;
            end
            pend_d     = cur_q;
            pend_vld_d = 1'b1;
          end else if (cur_cnt < CNT_M1) begin
            wr_data = cur_cnt + CNT_P1;
          end else if (cur_cnt > CNT_P1) begin
            wr_data = cur_cnt - CNT_P1;
          end else begin
            wr_data = cur_cnt;
          end
          if (cur_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cur_q + 1'b1;
            cur_d   = cur_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_vld_q) begin
          if (out_free) begin
            out_d.repeat_key = KEY_W'(pend_q);
            out_d.last       = 1'b1;
            out_vld_d        = 1'b1;
            pend_vld_d       = 1'b0;
            state_d          = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      delay_q    <= DEFAULT_DELAY;
      period_q   <= DEFAULT_PERIOD;
      held_q     <= '0;
      key_q      <= '0;
      cur_q      <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      out_q      <= '0;
      out_vld_q  <= 1'b0;
      ent_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      key_q      <= key_d;
      cur_q      <= cur_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      out_q      <= out_d;
      out_vld_q  <= out_vld_d;
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= ent_vld_q[rd_addr];
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_DELAY) begin
          delay_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_PERIOD) begin
          period_q <= cfg_data_i;
        end
      end
    end
  end

endmodule

/* tb/sv/tb_key_autorepeat_engine.sv */
// testbench for the key autorepeat engine: random key and tick traffic checked against a predictor
`timescale 1ns / 1ps
module tb_key_autorepeat_engine import kae_pkg::*; ();

  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 80;
  localparam int unsigned STALL_LIMIT = 4000;

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  kae_in_t              in_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  kae_out_t             out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  // predictor state
  byte              key_cnt [NUM_KEYS_DEF];
  logic [HELD_W-1:0] held_keys  = '0;
  logic [CFG_W-1:0]  delay_cfg  = DEFAULT_DELAY;
  logic [CFG_W-1:0]  period_cfg = DEFAULT_PERIOD;

  kae_in_t  event_q [$];
  kae_out_t repeat_q [$];
  int       queued_n     = 0;
  int       accepted_n   = 0;
  int       errors       = 0;
  int       stall_cycles = 0;
  logic     in_fire      = 1'b0;
  logic     cfg_fire     = 1'b0;
  bit       no_idle      = 1'b0;
  int       hold_asked   = 0;
  int       hold_taken   = 0;
  int       hold_left    = 0;

  key_autorepeat_engine #(.NUM_KEYS(NUM_KEYS_DEF)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void advance_repeat_state(kae_in_t item);
    kae_out_t burst [$];
    kae_out_t rep;
    if (item.kind == KIND_DOWN) begin
      if (!item.is_modifier) begin
        if (key_cnt[item.key] == 0) begin
          if (held_keys < HELD_MAX) held_keys++;
          key_cnt[item.key] = -byte'(delay_cfg);
        end else begin
          key_cnt[item.key] = byte'(period_cfg);
        end
      end
    end else if (item.kind == KIND_UP) begin
      if (held_keys != 0) held_keys--;
      key_cnt[item.key] = 0;
    end else if (item.kind == KIND_TICK && held_keys != 0) begin
      for (int n = 0; n < NUM_KEYS_DEF; n++) begin
        if (key_cnt[n] == -1 || key_cnt[n] == 1) begin
          rep.repeat_key = KEY_W'(n);
          rep.last       = 1'b0;
          burst.push_back(rep);
          key_cnt[n] = byte'(period_cfg);
        end else if (key_cnt[n] < -1) begin
          key_cnt[n]++;
        end else if (key_cnt[n] > 1) begin
          key_cnt[n]--;
        end
      end
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) repeat_q.push_back(burst[i]);
    end
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (event_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_i       <= event_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken  <= hold_taken + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    kae_out_t exp_rep;
    in_fire  <= in_valid_i && in_ready_o;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_repeat_state(in_i);
        accepted_n++;
      end
      if (out_valid_o && out_ready_i) begin
        if (repeat_q.size() == 0) begin
          $error("unexpected repeat transaction: repeat_key %0d", out_o.repeat_key);
          errors++;
        end else begin
          exp_rep = repeat_q.pop_front();
          if (out_o.repeat_key !== exp_rep.repeat_key) begin
            $error("repeat_key: expected %0d, actual %0d", exp_rep.repeat_key,
                   out_o.repeat_key);
            errors++;
          end
          if (out_o.last !== exp_rep.last) begin
            $error("last: expected %0d, actual %0d", exp_rep.last, out_o.last);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("[key_autorepeat_engine] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_event(input logic [1:0] kind, input int key, input bit modifier);
    kae_in_t item;
    item.kind        = kind;
    item.key         = KEY_W'(key);
    item.is_modifier = modifier;
    event_q.push_back(item);
    queued_n++;
  endtask

  task automatic queue_mix(input int n, input int key_hi, input int tick_pct);
    int r;
    int k;
    repeat (n) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 99) < 85) ? $urandom_range(0, key_hi) : $urandom_range(0, 63);
      if (r < tick_pct) queue_event(KIND_TICK, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      else if (r < tick_pct + 20) queue_event(KIND_UP, k, 1'($urandom_range(0, 1)));
      else if (r < 95) queue_event(KIND_DOWN, k, $urandom_range(0, 9) == 0);
      else queue_event(KIND_UNUSED, k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (accepted_n != queued_n || repeat_q.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i = 1'b0;
    if (idx == CFG_DELAY) delay_cfg = data;
    else if (idx == CFG_PERIOD) period_cfg = data;
  endtask

  initial begin
    int order [NUM_KEYS_DEF];
    int j;
    int t;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings
    queue_mix(20, 3, 60);
    settle();

    // directed corners
    write_reg(CFG_DELAY, 7'd2);
    write_reg(CFG_PERIOD, 7'd1);
    queue_event(KIND_DOWN, 0, 1'b0);
    queue_event(KIND_DOWN, 63, 1'b0);
    queue_event(KIND_DOWN, 5, 1'b1);
    queue_event(KIND_UNUSED, 42, 1'b1);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_DOWN, 0, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_UP, 63, 1'b1);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_UP, 0, 1'b0);
    queue_event(KIND_UP, 0, 1'b0);
    queue_event(KIND_UP, 21, 1'b0);
    queue_event(KIND_DOWN, 42, 1'b0);
    queue_event(KIND_UP, 7, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_DOWN, 42, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_DOWN, 10, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_TICK, 0, 1'b0);
    queue_event(KIND_TICK, 63, 1'b1);
    settle();

    // every key held, full bursts while the receiver holds off
    write_reg(CFG_DELAY, 7'd1);
    foreach (order[i]) order[i] = i;
    for (int i = NUM_KEYS_DEF - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) queue_event(KIND_DOWN, order[i], 1'b0);
    repeat (3) queue_event(KIND_TICK, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
    hold_asked++;
    queue_mix(30, 63, 40);
    settle();

    // zero delay and period, held count saturation
    write_reg(CFG_DELAY, 7'd0);
    write_reg(CFG_PERIOD, 7'd0);
    repeat (132) queue_event(KIND_DOWN, $urandom_range(0, 63), 1'b0);
    queue_mix(10, 63, 30);
    settle();
    write_reg(CFG_DELAY, 7'd3);
    queue_mix(20, 5, 50);
    settle();

    // largest settings
    write_reg(CFG_DELAY, 7'd127);
    write_reg(CFG_PERIOD, 7'd127);
    queue_mix(25, 3, 50);
    settle();
    write_reg(CFG_DELAY, 7'd1);
    queue_mix(25, 3, 50);
    settle();

    // back to back, with a sender pause in the middle
    write_reg(CFG_DELAY, 7'd4);
    write_reg(CFG_PERIOD, 7'd2);
    no_idle = 1'b1;
    queue_mix(25, 7, 45);
    wait_drained();
    queue_mix(25, 7, 45);
    wait_drained();
    no_idle = 1'b0;
    settle();

    // spare indexes, then random small settings
    write_reg(CFG_SPARE_A, CFG_W'($urandom_range(0, 127)));
    write_reg(CFG_SPARE_B, CFG_W'($urandom_range(0, 127)));
    write_reg(CFG_DELAY, CFG_W'($urandom_range(1, 6)));
    write_reg(CFG_PERIOD, CFG_W'($urandom_range(1, 4)));
    queue_mix(20, 7, 45);
    settle();

    if (errors == 0 && repeat_q.size() == 0) begin
      $display("[key_autorepeat_engine] OK");
    end else begin
      $display("[key_autorepeat_engine] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/kae_pkg.sv
sv/key_autorepeat_engine.sv
tb/sv/tb_key_autorepeat_engine.sv
